### rtl/core/smpq_pkg.sv
package smpq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OUT_CNT_W = 5;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
   } ctl_type;

endpackage

### rtl/core/sorted_max_priority_queue_unit.sv
// Channel  Dir  Beat fields (low bit first)
// req      in   tuser: opcode[1:0]; tdata: item_value[31:0]
// rsp      out  tuser: status[1:0]; tdata: popped_value[31:0], entry_count[36:32], zero pad
//
// One beat per cycle while the response is not stalled: every cell compares against
// the pushed value in parallel and shifts toward its neighbor in the same cycle, so
// the result is registered directly from the request beat.
// Synchronous reset empties the queue and drops any pending response beat.
// A stalled response holds its register; a new request is taken in the cycle the
// held beat leaves.
module sorted_max_priority_queue_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   input  logic [31:0] req_tdata,   // item_value[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic [39:0] rsp_tdata    // popped_value[31:0], entry_count[36:32], zero[39:37]
);

   localparam int N = smpq_pkg::CAPACITY;
   localparam int W = smpq_pkg::VAL_W;
   localparam int C = smpq_pkg::CNT_W;

   logic [C-1:0] count_ff, count_in;
   logic         rsp_valid_ff;
   logic [W-1:0] rsp_value_ff;
   logic [1:0]   rsp_status_ff;
   logic [smpq_pkg::OUT_CNT_W-1:0] rsp_count_ff;

   logic                accept;
   logic                full, empty;
   logic [1:0]          status;
   smpq_pkg::ctl_type   ctl;
   logic signed [W-1:0] push_value;
   logic signed [W-1:0] entry [N];
   logic                keep  [N];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign push_value = req_tdata;
   assign full       = (count_ff == C'(N));
   assign empty      = (count_ff == '0);

   always_comb begin
      ctl.push = accept && (req_tuser == smpq_pkg::OP_PUSH) && !full;
      ctl.pop  = accept && (req_tuser == smpq_pkg::OP_POP) && !empty;
      count_in = count_ff;
      status   = smpq_pkg::ST_OK;
      if (accept) begin
         case (req_tuser)
            smpq_pkg::OP_PUSH: begin
               if (full) begin
                  status = smpq_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + C'(1);
               end
            end
            smpq_pkg::OP_POP: begin
               if (empty) begin
                  status = smpq_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - C'(1);
               end
            end
            smpq_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cell
      smpq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (C'(i) < count_ff),
         .push_value (push_value),
         .prev_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
         .prev_entry (entry[(i == 0) ? 0 : i - 1]),
         .next_entry (entry[(i == N - 1) ? N - 1 : i + 1]),
         .keep       (keep[i]),
         .entry      (entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= ctl.pop ? entry[0] : '0;
         rsp_status_ff <= status;
         rsp_count_ff  <= smpq_pkg::OUT_CNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_value_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= C'(N))
      else $error("held count above capacity");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= C'(2)) |-> (entry[0] >= entry[1]))
      else $error("front entries out of order");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |=> (count_ff == $past(count_ff) - C'(1)))
      else $error("pop did not reduce count");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == smpq_pkg::ST_EMPTY) |-> (rsp_value_ff == '0))
      else $error("empty pop returned nonzero value");

endmodule

### rtl/core/smpq_cell.sv
module smpq_cell (
   input  logic                              clock,
   input  smpq_pkg::ctl_type                 ctl,
   input  logic                              occupied,
   input  logic signed [smpq_pkg::VAL_W-1:0] push_value,
   input  logic                              prev_keep,
   input  logic signed [smpq_pkg::VAL_W-1:0] prev_entry,
   input  logic signed [smpq_pkg::VAL_W-1:0] next_entry,
   output logic                              keep,
   output logic signed [smpq_pkg::VAL_W-1:0] entry
);

   logic signed [smpq_pkg::VAL_W-1:0] entry_ff;
   logic signed [smpq_pkg::VAL_W-1:0] entry_in;

   // entries >= the pushed value stay ahead of it
   assign keep  = occupied && (entry_ff >= push_value);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (prev_keep) begin
            entry_in = push_value;
         end else begin
            entry_in = prev_entry;
         end
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
